### design/lrgs_pkg.sv
package lrgs_pkg;

  localparam int PANEL_WIDTH_DEF  = 240;
  localparam int PANEL_HEIGHT_DEF = 240;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_FILL = 2'd1;
  localparam logic [1:0] REQ_CHAR = 2'd2;

  localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

  localparam logic [2:0] CELL_LAST_ROW  = 3'd7;
  localparam logic [2:0] CELL_BLANK_COL = 3'd5;

  typedef enum logic [1:0] {
    JOB_TICK,
    JOB_FILL,
    JOB_CHAR,
    JOB_NOP
  } job_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CMD_X,
    PH_WIN_X,
    PH_CMD_Y,
    PH_WIN_Y,
    PH_CMD_MEM,
    PH_PIXELS
  } phase_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [39:0] glyph_columns;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [7:0]  scale;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] byte_out;
    logic       burst_end;
    logic       last;
  } out_item_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [15:0] fg;
    logic [15:0] bg;
    logic [39:0] glyph;
    logic [7:0]  scale;
  } job_t;

endpackage

### design/lcd_rect_and_glyph_byte_streamer.sv
// Byte streamer for an RGB565 SPI panel: a fill-rectangle or draw-character
// transfer loads a job, and each later tick transfer yields one SPI byte
// (column window, row window, memory write command, then pixels, high byte
// first). One input transfer is taken every clock while the queue has room;
// each item passes through the front classification register and then the
// queue, and a tick's byte is then registered in the output register behind
// out_valid, where it is held while the output is stalled. The rate is set by
// the sequencer, which retires one queued item per clock while the output is
// not stalled. Starts that arrive while a job is running, ticks while no
// job runs, empty fills and unknown request types are dropped, no result.
module lcd_rect_and_glyph_byte_streamer #(
  parameter int PANEL_WIDTH  = lrgs_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lrgs_pkg::PANEL_HEIGHT_DEF,
  parameter int QUEUE_DEPTH  = lrgs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lrgs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lrgs_pkg::out_item_t out_data
);

  logic           q_full, q_push, q_pop, q_valid;
  lrgs_pkg::job_t q_wdata, q_rdata;

  lrgs_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  lrgs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rvalid(q_valid),
    .rdata (q_rdata)
  );

  lrgs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

### design/lrgs_front.sv
module lrgs_front #(
  parameter int PANEL_WIDTH  = lrgs_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lrgs_pkg::PANEL_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lrgs_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output lrgs_pkg::job_t    q_wdata
);

  localparam logic [15:0] PW = 16'(PANEL_WIDTH);
  localparam logic [15:0] PH = 16'(PANEL_HEIGHT);

  logic           valid_r, valid_nxt;
  lrgs_pkg::job_t job_r, job_nxt;
  logic           accept;
  logic [15:0]    xe_clip, ye_clip;
  logic [7:0]     scale_eff;

  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = valid_r && !q_full;
  assign q_wdata  = job_r;

  assign xe_clip   = (in_data.x_end > PW) ? PW : in_data.x_end;
  assign ye_clip   = (in_data.y_end > PH) ? PH : in_data.y_end;
  assign scale_eff = (in_data.scale == 8'd0) ? 8'd1 : in_data.scale;

  always_comb begin
    job_nxt.kind  = lrgs_pkg::JOB_NOP;
    job_nxt.x0    = in_data.x_start;
    job_nxt.y0    = in_data.y_start;
    job_nxt.x1    = xe_clip - 16'd1;
    job_nxt.y1    = ye_clip - 16'd1;
    job_nxt.fg    = in_data.fg_color;
    job_nxt.bg    = in_data.bg_color;
    job_nxt.glyph = in_data.glyph_columns;
    job_nxt.scale = scale_eff;
    case (in_data.req_type)
      lrgs_pkg::REQ_TICK: begin
        job_nxt.kind = lrgs_pkg::JOB_TICK;
      end
      lrgs_pkg::REQ_FILL: begin
        if (in_data.x_start >= xe_clip || in_data.y_start >= ye_clip) begin
          job_nxt.kind = lrgs_pkg::JOB_NOP;
        end else begin
          job_nxt.kind = lrgs_pkg::JOB_FILL;
        end
      end
      lrgs_pkg::REQ_CHAR: begin
        job_nxt.kind = lrgs_pkg::JOB_CHAR;
        job_nxt.x1   = in_data.x_start + {6'd0, scale_eff, 2'b00}
                       + {7'd0, scale_eff, 1'b0} - 16'd1;
        job_nxt.y1   = in_data.y_start + {5'd0, scale_eff, 3'b000} - 16'd1;
      end
      default: begin
        job_nxt.kind = lrgs_pkg::JOB_NOP;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

endmodule

### design/lrgs_queue.sv
module lrgs_queue #(
  parameter int DEPTH = lrgs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lrgs_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           rvalid,
  output lrgs_pkg::job_t rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lrgs_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full   = (count_r == CNT_FULL);
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];
  assign do_pop = pop && rvalid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### design/lrgs_back.sv
module lrgs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lrgs_pkg::job_t     q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lrgs_pkg::out_item_t out_data
);

  lrgs_pkg::phase_t    phase_r, phase_nxt;
  logic [1:0]          wcnt_r, wcnt_nxt;
  logic                low_r, low_nxt;
  logic                char_r, char_nxt;
  logic [15:0]         x0_r, x0_nxt, x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [15:0]         fx_r, fx_nxt, fy_r, fy_nxt;
  logic [2:0]          row_r, row_nxt, col_r, col_nxt;
  logic [7:0]          row_rep_r, row_rep_nxt, col_rep_r, col_rep_nxt;
  logic [15:0]         fg_r, fg_nxt, bg_r, bg_nxt;
  logic [39:0]         glyph_r, glyph_nxt;
  logic [7:0]          scale_r, scale_nxt;
  logic                out_valid_r, out_valid_nxt;
  lrgs_pkg::out_item_t out_r, ob;
  logic                out_free, emit, fin, char_fin, pix_on;
  logic [7:0]          col_byte;
  logic [15:0]         color, coord;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (col_r)
      3'd0:    col_byte = glyph_r[7:0];
      3'd1:    col_byte = glyph_r[15:8];
      3'd2:    col_byte = glyph_r[23:16];
      3'd3:    col_byte = glyph_r[31:24];
      3'd4:    col_byte = glyph_r[39:32];
      default: col_byte = 8'd0;
    endcase
  end

  assign pix_on   = col_byte[row_r];
  assign color    = (!char_r || pix_on) ? fg_r : bg_r;
  assign char_fin = (row_r == lrgs_pkg::CELL_LAST_ROW) && (row_rep_r + 8'd1 == scale_r)
                    && (col_r == lrgs_pkg::CELL_BLANK_COL) && (col_rep_r + 8'd1 == scale_r);
  assign fin      = char_r ? char_fin : (fx_r == x1_r && fy_r == y1_r);
  assign coord    = (phase_r == lrgs_pkg::PH_WIN_X) ? (wcnt_r[1] ? x1_r : x0_r)
                                                    : (wcnt_r[1] ? y1_r : y0_r);

  always_comb begin
    phase_nxt   = phase_r;
    wcnt_nxt    = wcnt_r;
    low_nxt     = low_r;
    char_nxt    = char_r;
    x0_nxt      = x0_r;
    x1_nxt      = x1_r;
    y0_nxt      = y0_r;
    y1_nxt      = y1_r;
    fx_nxt      = fx_r;
    fy_nxt      = fy_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    row_rep_nxt = row_rep_r;
    col_rep_nxt = col_rep_r;
    fg_nxt      = fg_r;
    bg_nxt      = bg_r;
    glyph_nxt   = glyph_r;
    scale_nxt   = scale_r;
    emit        = 1'b0;
    ob          = '0;
    if (q_pop) begin
      unique case (q_rdata.kind) inside
        lrgs_pkg::JOB_FILL, lrgs_pkg::JOB_CHAR: begin
          if (phase_r == lrgs_pkg::PH_IDLE) begin
            x0_nxt    = q_rdata.x0;
            x1_nxt    = q_rdata.x1;
            y0_nxt    = q_rdata.y0;
            y1_nxt    = q_rdata.y1;
            fg_nxt    = q_rdata.fg;
            low_nxt   = 1'b0;
            wcnt_nxt  = 2'd0;
            phase_nxt = lrgs_pkg::PH_CMD_X;
            if (q_rdata.kind == lrgs_pkg::JOB_CHAR) begin
              char_nxt    = 1'b1;
              bg_nxt      = q_rdata.bg;
              glyph_nxt   = q_rdata.glyph;
              scale_nxt   = q_rdata.scale;
              row_nxt     = 3'd0;
              col_nxt     = 3'd0;
              row_rep_nxt = 8'd0;
              col_rep_nxt = 8'd0;
            end else begin
              char_nxt = 1'b0;
              fx_nxt   = q_rdata.x0;
              fy_nxt   = q_rdata.y0;
            end
          end
        end
        lrgs_pkg::JOB_TICK: begin
          if (phase_r != lrgs_pkg::PH_IDLE) begin
            emit = 1'b1;
            unique case (phase_r) inside
              lrgs_pkg::PH_CMD_X: begin
                ob        = '{is_data: 1'b0, byte_out: lrgs_pkg::CMD_COL_ADDR,
                              burst_end: 1'b1, last: 1'b0};
                phase_nxt = lrgs_pkg::PH_WIN_X;
                wcnt_nxt  = 2'd0;
              end
              lrgs_pkg::PH_CMD_Y: begin
                ob        = '{is_data: 1'b0, byte_out: lrgs_pkg::CMD_ROW_ADDR,
                              burst_end: 1'b1, last: 1'b0};
                phase_nxt = lrgs_pkg::PH_WIN_Y;
                wcnt_nxt  = 2'd0;
              end
              lrgs_pkg::PH_CMD_MEM: begin
                ob        = '{is_data: 1'b0, byte_out: lrgs_pkg::CMD_MEM_WR,
                              burst_end: 1'b1, last: 1'b0};
                phase_nxt = lrgs_pkg::PH_PIXELS;
                low_nxt   = 1'b0;
              end
              lrgs_pkg::PH_WIN_X, lrgs_pkg::PH_WIN_Y: begin
                ob.is_data   = 1'b1;
                ob.byte_out  = wcnt_r[0] ? coord[7:0] : coord[15:8];
                ob.burst_end = (wcnt_r == 2'd3);
                if (wcnt_r == 2'd3) begin
                  wcnt_nxt  = 2'd0;
                  phase_nxt = (phase_r == lrgs_pkg::PH_WIN_X) ? lrgs_pkg::PH_CMD_Y
                                                              : lrgs_pkg::PH_CMD_MEM;
                end else begin
                  wcnt_nxt = wcnt_r + 2'd1;
                end
              end
              lrgs_pkg::PH_PIXELS: begin
                ob.is_data = 1'b1;
                if (!low_r) begin
                  ob.byte_out = color[15:8];
                  low_nxt     = 1'b1;
                end else begin
                  ob.byte_out  = color[7:0];
                  ob.burst_end = fin;
                  ob.last      = fin;
                  low_nxt      = 1'b0;
                  if (fin) begin
                    phase_nxt   = lrgs_pkg::PH_IDLE;
                    row_nxt     = 3'd0;
                    col_nxt     = 3'd0;
                    row_rep_nxt = 8'd0;
                    col_rep_nxt = 8'd0;
                  end else if (char_r) begin
                    if (col_rep_r + 8'd1 != scale_r) begin
                      col_rep_nxt = col_rep_r + 8'd1;
                    end else begin
                      col_rep_nxt = 8'd0;
                      if (col_r != lrgs_pkg::CELL_BLANK_COL) begin
                        col_nxt = col_r + 3'd1;
                      end else begin
                        col_nxt = 3'd0;
                        if (row_rep_r + 8'd1 != scale_r) begin
                          row_rep_nxt = row_rep_r + 8'd1;
                        end else begin
                          row_rep_nxt = 8'd0;
                          row_nxt     = row_r + 3'd1;
                        end
                      end
                    end
                  end else begin
                    if (fx_r == x1_r) begin
                      fx_nxt = x0_r;
                      fy_nxt = fy_r + 16'd1;
                    end else begin
                      fx_nxt = fx_r + 16'd1;
                    end
                  end
                end
              end
              default: begin
                emit      = 1'b0;
                phase_nxt = lrgs_pkg::PH_IDLE;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
    out_valid_nxt = out_free ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lrgs_pkg::PH_IDLE;
      wcnt_r      <= 2'd0;
      low_r       <= 1'b0;
      char_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      wcnt_r      <= wcnt_nxt;
      low_r       <= low_nxt;
      char_r      <= char_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r      <= x0_nxt;
    x1_r      <= x1_nxt;
    y0_r      <= y0_nxt;
    y1_r      <= y1_nxt;
    fx_r      <= fx_nxt;
    fy_r      <= fy_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    row_rep_r <= row_rep_nxt;
    col_rep_r <= col_rep_nxt;
    fg_r      <= fg_nxt;
    bg_r      <= bg_nxt;
    glyph_r   <= glyph_nxt;
    scale_r   <= scale_nxt;
    if (emit) begin
      out_r <= ob;
    end
  end

endmodule

### design/lrgs_checker.sv
module lrgs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lrgs_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.burst_end && out_data.is_data)
    else $error("final byte without burst end");

  a_cmd_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_data |-> out_data.burst_end && !out_data.last)
    else $error("command byte framing wrong");

  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_data |->
      out_data.byte_out == lrgs_pkg::CMD_COL_ADDR ||
      out_data.byte_out == lrgs_pkg::CMD_ROW_ADDR ||
      out_data.byte_out == lrgs_pkg::CMD_MEM_WR)
    else $error("unknown command byte");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind lcd_rect_and_glyph_byte_streamer lrgs_checker u_lrgs_checker (.*);
